### sv/cnchs_pkg.sv
package cnchs_pkg;

  localparam int AXIS_COUNT = 4;
  localparam int AXIS_BITS = 2;
  localparam int AXIS_SLOTS = 4;

  localparam logic [AXIS_SLOTS-1:0] AXES_WIDTH_MASK = 4'h0F;
  localparam logic [AXIS_SLOTS-1:0] VALID_AXES =
    AXIS_SLOTS'(((1 << AXIS_COUNT) - 1)) & AXES_WIDTH_MASK;

  localparam int IN_DATA_W = 16;
  localparam int IN_USER_W = 2;
  localparam int OUT_DATA_W = 24;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 4;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_ABORT = 2'd2,
    CMD_CLEAR = 2'd3
  } command_t;

  localparam logic [CFG_INDEX_W-1:0] REG_HOMING_ENABLED = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DIRECTION_MASK = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LIMIT_INVERT = 2'd2;

  typedef enum logic [5:0] {
    ST_IDLE       = 6'b000001,
    ST_SEEK       = 6'b000010,
    ST_BACKOFF    = 6'b000100,
    ST_REAPPROACH = 6'b001000,
    ST_PULLOFF    = 6'b010000,
    ST_ALARM      = 6'b100000
  } phase_t;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_SEEK = 3'd1;
  localparam logic [2:0] PH_BACKOFF = 3'd2;
  localparam logic [2:0] PH_REAPPROACH = 3'd3;
  localparam logic [2:0] PH_PULLOFF = 3'd4;
  localparam logic [2:0] PH_ALARM = 3'd6;

  localparam logic [1:0] MK_SEEK = 2'd0;
  localparam logic [1:0] MK_BACKOFF = 2'd1;
  localparam logic [1:0] MK_REAPPROACH = 2'd2;
  localparam logic [1:0] MK_PULLOFF = 2'd3;

  localparam logic [1:0] ALM_NONE = 2'd0;
  localparam logic [1:0] ALM_NOT_FOUND = 2'd1;
  localparam logic [1:0] ALM_STILL_SET = 2'd2;

  localparam logic [AXIS_BITS-1:0] AXIS_ORDER [AXIS_SLOTS] = '{2'd2, 2'd1, 2'd0, 2'd3};

  function automatic logic [2:0] phase_code(input phase_t p);
    logic [2:0] c;
    case (p)
      ST_IDLE:       c = PH_IDLE;
      ST_SEEK:       c = PH_SEEK;
      ST_BACKOFF:    c = PH_BACKOFF;
      ST_REAPPROACH: c = PH_REAPPROACH;
      ST_PULLOFF:    c = PH_PULLOFF;
      ST_ALARM:      c = PH_ALARM;
      default:       c = PH_IDLE;
    endcase
    return c;
  endfunction

endpackage

### sv/cnc_homing_sequencer.sv
// channel | dir | handshake                 | payload
// s       | in  | s_tvalid / s_tready       | s_tuser command, s_tdata status
// m       | out | m_tvalid / m_tready       | m_tdata one result word per input word
// cfg     | in  | cfg_valid / cfg_ready     | cfg_index, cfg_data
// One input word is taken every cycle while the result register is free; its result is
// registered and appears in the cycle after. A single pass of the next-state logic lies
// between the input port and the result register for each word.
// rst is synchronous and clears state, the result valid flag and the configuration registers.
// A stalled result holds; input is taken while the result register is empty
// or is being drained in the same cycle. cfg_ready is always high.
module cnc_homing_sequencer (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // home_mask[3:0], limit_min_pins[7:4], limit_max_pins[11:8],
  // motion_idle[12], queue_empty[13], zero[15:14]
  input  logic [cnchs_pkg::IN_DATA_W-1:0]    s_tdata,
  // command[1:0]
  input  logic [cnchs_pkg::IN_USER_W-1:0]    s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // start_accepted[0], phase[3:1], active_axis[5:4], homed_axes[9:6],
  // alarm[11:10], move_start[12], move_kind[14:13], move_positive[15],
  // zero_axis_position[16], sync_axis_position[17], steppers_disable[18],
  // all_homed[19], zero[23:20]
  output logic [cnchs_pkg::OUT_DATA_W-1:0]   m_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [cnchs_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [cnchs_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import cnchs_pkg::*;

  logic                 homing_enabled;
  logic [3:0]           direction_mask;
  logic [3:0]           limit_invert_mask;

  phase_t               phase_reg, phase_reg_next;
  logic [3:0]           axes_pending, axes_pending_next;
  logic [3:0]           axes_done, axes_done_next;
  logic [AXIS_BITS-1:0] current_axis_reg, current_axis_reg_next;
  logic [1:0]           alarm_reg, alarm_reg_next;
  logic                 limit_previous, limit_previous_next;
  logic                 machine_homed_flag, machine_homed_flag_next;

  logic                 accepted, mv_start, mv_pos, zero_pos, sync_pos;
  logic [1:0]           mv_kind;
  logic [OUT_DATA_W-1:0] result_next;

  command_t             cmd;
  logic [3:0]           mask, mins, maxs;
  logic                 idle, qempty;
  logic                 in_acc;

  assign cmd    = command_t'(s_tuser[1:0]);
  assign mask   = s_tdata[3:0];
  assign mins   = s_tdata[7:4];
  assign maxs   = s_tdata[11:8];
  assign idle   = s_tdata[12];
  assign qempty = s_tdata[13];

  assign s_tready  = !m_tvalid || m_tready;
  assign in_acc    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  function automatic logic limit_of(input logic [AXIS_BITS-1:0] ax, input logic [3:0] mn,
                                    input logic [3:0] mx, input logic [3:0] dir,
                                    input logic [3:0] inv);
    logic pin;
    pin = dir[ax] ? mx[ax] : mn[ax];
    return pin ^ inv[ax];
  endfunction

  always_comb begin
    logic                 found;
    logic                 after;
    logic [AXIS_BITS-1:0] pick;
    logic                 now;
    logic                 edge_hit;
    logic                 lim_cur;
    logic                 seek_next;

    phase_reg_next          = phase_reg;
    axes_pending_next       = axes_pending;
    axes_done_next          = axes_done;
    current_axis_reg_next   = current_axis_reg;
    alarm_reg_next          = alarm_reg;
    limit_previous_next     = limit_previous;
    machine_homed_flag_next = machine_homed_flag;
    accepted  = 1'b0;
    mv_start  = 1'b0;
    mv_kind   = MK_SEEK;
    mv_pos    = 1'b0;
    zero_pos  = 1'b0;
    sync_pos  = 1'b0;
    found     = 1'b0;
    after     = 1'b0;
    pick      = current_axis_reg;
    seek_next = 1'b0;
    edge_hit  = 1'b0;
    now       = limit_of(current_axis_reg, mins, maxs, direction_mask, limit_invert_mask);

    case (cmd)
      CMD_START: begin
        if (phase_reg == ST_IDLE && mask != 4'd0 && (mask & ~VALID_AXES) == 4'd0
            && homing_enabled) begin
          accepted          = 1'b1;
          axes_pending_next = mask;
          axes_done_next    = 4'd0;
          alarm_reg_next    = ALM_NONE;
          for (int i = 0; i < AXIS_SLOTS; i++) begin
            if (!found && int'(AXIS_ORDER[i]) < AXIS_COUNT && mask[AXIS_ORDER[i]]) begin
              found = 1'b1;
              pick  = AXIS_ORDER[i];
            end
          end
          current_axis_reg_next = pick;
          seek_next = 1'b1;
        end
      end
      CMD_ABORT: begin
        phase_reg_next      = ST_IDLE;
        alarm_reg_next      = ALM_NONE;
        limit_previous_next = 1'b0;
      end
      CMD_CLEAR: begin
        if (phase_reg == ST_ALARM) begin
          phase_reg_next = ST_IDLE;
          alarm_reg_next = ALM_NONE;
        end
      end
      default: begin
        if (phase_reg == ST_SEEK || phase_reg == ST_REAPPROACH) begin
          edge_hit            = now && !limit_previous;
          limit_previous_next = now;
        end
        if (edge_hit && phase_reg == ST_SEEK) begin
          phase_reg_next = ST_BACKOFF;
          mv_start       = 1'b1;
          mv_kind        = MK_BACKOFF;
          mv_pos         = !direction_mask[current_axis_reg];
        end else if (edge_hit) begin
          zero_pos       = 1'b1;
          phase_reg_next = ST_PULLOFF;
          mv_start       = 1'b1;
          mv_kind        = MK_PULLOFF;
          mv_pos         = !direction_mask[current_axis_reg];
        end else begin
          case (phase_reg)
            ST_SEEK: begin
              if (idle) begin
                phase_reg_next = ST_ALARM;
                alarm_reg_next = ALM_NOT_FOUND;
              end
            end
            ST_BACKOFF: begin
              if (qempty) begin
                limit_previous_next = 1'b0;
                phase_reg_next      = ST_REAPPROACH;
                mv_start            = 1'b1;
                mv_kind             = MK_REAPPROACH;
                mv_pos              = direction_mask[current_axis_reg];
              end
            end
            ST_REAPPROACH: begin
              if (qempty) begin
                phase_reg_next = ST_ALARM;
                alarm_reg_next = ALM_NOT_FOUND;
              end
            end
            ST_PULLOFF: begin
              if (idle) begin
                if (now) begin
                  phase_reg_next = ST_ALARM;
                  alarm_reg_next = ALM_STILL_SET;
                end else begin
                  axes_done_next = axes_done | (4'd1 << current_axis_reg);
                  sync_pos       = 1'b1;
                  // search only the slots that follow the current axis
                  for (int i = 0; i < AXIS_SLOTS; i++) begin
                    if (after && !found && int'(AXIS_ORDER[i]) < AXIS_COUNT
                        && axes_pending[AXIS_ORDER[i]]) begin
                      found = 1'b1;
                      pick  = AXIS_ORDER[i];
                    end
                    if (AXIS_ORDER[i] == current_axis_reg) after = 1'b1;
                  end
                  if (found) begin
                    current_axis_reg_next = pick;
                    seek_next = 1'b1;
                  end else begin
                    phase_reg_next          = ST_IDLE;
                    machine_homed_flag_next = 1'b1;
                  end
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
    endcase

    if (seek_next) begin
      lim_cur             = limit_of(pick, mins, maxs, direction_mask, limit_invert_mask);
      limit_previous_next = 1'b0;
      mv_start            = 1'b1;
      if (lim_cur) begin
        phase_reg_next = ST_BACKOFF;
        mv_kind        = MK_BACKOFF;
        mv_pos         = !direction_mask[pick];
      end else begin
        phase_reg_next = ST_SEEK;
        mv_kind        = MK_SEEK;
        mv_pos         = direction_mask[pick];
      end
    end else begin
      lim_cur = 1'b0;
    end

    result_next = {4'd0, machine_homed_flag_next, phase_reg_next == ST_ALARM,
                   sync_pos, zero_pos, mv_pos, mv_kind, mv_start, alarm_reg_next,
                   axes_done_next, current_axis_reg_next, phase_code(phase_reg_next),
                   accepted};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      homing_enabled    <= 1'b0;
      direction_mask    <= 4'd0;
      limit_invert_mask <= 4'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HOMING_ENABLED: homing_enabled    <= cfg_data[0];
        REG_DIRECTION_MASK: direction_mask    <= cfg_data[3:0];
        REG_LIMIT_INVERT:   limit_invert_mask <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg          <= ST_IDLE;
      axes_pending       <= 4'd0;
      axes_done          <= 4'd0;
      current_axis_reg   <= '0;
      alarm_reg          <= ALM_NONE;
      limit_previous     <= 1'b0;
      machine_homed_flag <= 1'b0;
    end else if (in_acc) begin
      phase_reg          <= phase_reg_next;
      axes_pending       <= axes_pending_next;
      axes_done          <= axes_done_next;
      current_axis_reg   <= current_axis_reg_next;
      alarm_reg          <= alarm_reg_next;
      limit_previous     <= limit_previous_next;
      machine_homed_flag <= machine_homed_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_acc) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      m_tdata <= result_next;
    end
  end

`ifndef SYNTHESIS
  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !in_acc |=> $stable(phase_reg) && $stable(axes_done) && $stable(current_axis_reg))
    else $error("state changed without an accepted word");

  a_start_moves: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[12] && m_tdata[11:10] == ALM_NONE)
    else $error("accepted start did not request a move");

  a_zero_pulloff: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[16] |-> m_tdata[12] && m_tdata[14:13] == MK_PULLOFF
                               && m_tdata[3:1] == PH_PULLOFF)
    else $error("zero strobe without pulloff request");

  a_alarm_disable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[18] == (m_tdata[3:1] == PH_ALARM)
                 && (m_tdata[18] == (m_tdata[11:10] != ALM_NONE)))
    else $error("steppers disable disagrees with alarm");

  a_homed_sticky: assert property (@(posedge clk) disable iff (rst)
    machine_homed_flag |=> machine_homed_flag)
    else $error("homed flag dropped");
`endif

endmodule
